### hdl/stnp_pkg.sv
// package for the square tone note player
// holds the item codes, state type and fixed widths; no dependencies
package stnp_pkg;

    localparam int unsigned RATE_W     = 18;
    localparam int unsigned FREQ_W     = 16;
    localparam int unsigned DUR_W      = 16;
    localparam int unsigned VOL_W      = 8;
    localparam int unsigned PHASE_W    = 32;
    localparam int unsigned LEFT_W     = 25;
    localparam int unsigned SAMPLE_W   = 14;
    localparam int unsigned HALF_W     = 13;
    localparam int unsigned PROD_W     = RATE_W + DUR_W;
    localparam int unsigned QUOT2_W    = 26;
    localparam int unsigned REM2_W     = 9;
    localparam int unsigned DIV_STEPS  = PROD_W;
    localparam int unsigned CNT_W      = 6;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 16;
    localparam int unsigned CFG_DATA_W = RATE_W;

    localparam logic [REM2_W:0]  DUR_DIV      = 10'd500;
    localparam logic [VOL_W-1:0] VOLUME_RST   = 8'd255;
    localparam logic [RATE_W-1:0] RATE_RST    = 18'd44100;

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_TICK   = 2'd1,
        FUNC_CANCEL = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        REG_VOLUME = 2'd0,
        REG_RATE   = 2'd1,
        REG_ENABLE = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

### hdl/square_tone_note_player_core.sv
// square tone note player: phase accumulator tone with bit-serial note setup
// depends on stnp_pkg
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------------
//  s        | in        | s_tvalid / s_tready   | s_tuser: func; s_tdata: note fields
//  m        | out       | m_tvalid / m_tready   | m_tdata: sample, need_note
//  cfg      | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// a tick beat's sample sits in the output register until taken
// a load beat is latched, then ST_DIV runs 34 steps of the two bit-serial
// dividers (phase step and sample count) side by side, the phase step one in the early steps only; ST_DONE commits
// cancel silences the tone and clears the remaining count; cfg writes are taken every cycle
// reset (rst_n low, async) restores register defaults and silences the tone
module square_tone_note_player_core
    import stnp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // note_playing[0], note_frequency[16:1], dur_units[32:17]
    input  logic [1:0]            s_tuser,   // func[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // sample[13:0], need_note[14]
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    state_t state_reg, state_next;

    logic [VOL_W-1:0]   volume_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic               enable_reg;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [PHASE_W-1:0] step_reg, step_next;
    logic [LEFT_W-1:0]  left_reg, left_next;
    logic               tone_reg, tone_next;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // divider working registers
    logic [CNT_W-1:0]   cnt_reg;
    logic [RATE_W-1:0]  rem1_reg;
    logic [PHASE_W-1:0] quot1_reg;
    logic               sat1_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [REM2_W-1:0]  rem2_reg;
    logic [QUOT2_W-1:0] quot2_reg;
    logic               play_reg;

    logic               in_beat;
    func_t              func;
    logic               note_playing;
    logic [FREQ_W-1:0]  note_frequency;
    logic [DUR_W-1:0]   dur_units;
    logic [DUR_W-1:0]   dur_eff;

    logic [RATE_W:0]    trial1;
    logic               take1;
    logic [REM2_W:0]    trial2;
    logic               take2;

    logic [LEFT_W-1:0]  left_eff;
    logic               tone_eff;
    logic [LEFT_W-1:0]  left_dec;
    logic [HALF_W-1:0]  half;
    logic [SAMPLE_W-1:0] sample;

    assign func           = func_t'(s_tuser);
    assign note_playing   = s_tdata[0];
    assign note_frequency = s_tdata[FREQ_W:1];
    assign dur_units      = s_tdata[FREQ_W+DUR_W:FREQ_W+1];
    assign dur_eff        = (dur_units == '0) ? DUR_W'(1) : dur_units;

    assign s_tready  = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign in_beat   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // one restoring step of each divider
    assign trial1 = {rem1_reg, 1'b0};
    assign take1  = (trial1 >= {1'b0, rate_reg});
    assign trial2 = {rem2_reg, prod_reg[PROD_W-1]};
    assign take2  = (trial2 >= DUR_DIV);

    // tick datapath
    assign left_eff = enable_reg ? left_reg : '0;
    assign tone_eff = enable_reg && tone_reg;
    assign left_dec = left_eff - LEFT_W'(1);
    assign half     = (volume_reg == '0) ? '0
                    : HALF_W'(({5'b0, volume_reg} + HALF_W'(1)) << 4);

    always_comb
    begin
        if (tone_eff && (left_eff != '0))
        begin
            sample = phase_reg[PHASE_W-1] ? {1'b0, half} : (-{1'b0, half});
        end
        else
        begin
            sample = '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        step_next      = step_reg;
        left_next      = left_reg;
        tone_next      = tone_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    case (func)
                        FUNC_LOAD:
                        begin
                            state_next = ST_DIV;
                        end
                        FUNC_CANCEL:
                        begin
                            tone_next = 1'b0;
                            left_next = '0;
                        end
                        FUNC_TICK:
                        begin
                            out_valid_next = 1'b1;
                            if (left_eff == '0)
                            begin
                                tone_next     = 1'b0;
                                left_next     = '0;
                                out_data_next = {1'b0, 1'b1, sample};
                            end
                            else
                            begin
                                tone_next = tone_eff;
                                left_next = left_dec;
                                if (tone_eff)
                                begin
                                    phase_next = phase_reg + step_reg;
                                end
                                out_data_next = {1'b0, (left_dec == '0), sample};
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                step_next  = sat1_reg ? '1 : quot1_reg;
                left_next  = quot2_reg[QUOT2_W-1] ? '1 : quot2_reg[LEFT_W-1:0];
                tone_next  = play_reg;
                phase_next = '0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            step_reg      <= '0;
            left_reg      <= '0;
            tone_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            volume_reg    <= VOLUME_RST;
            rate_reg      <= RATE_RST;
            enable_reg    <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            left_reg      <= left_next;
            tone_reg      <= tone_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_VOLUME: volume_reg <= cfg_data[VOL_W-1:0];
                    REG_RATE:   rate_reg   <= cfg_data;
                    REG_ENABLE: enable_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload and divider registers
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (in_beat && (func == FUNC_LOAD))
        begin
            cnt_reg   <= '0;
            rem1_reg  <= RATE_W'(note_frequency);
            sat1_reg  <= ({2'b0, note_frequency} >= rate_reg);
            quot1_reg <= '0;
            prod_reg  <= PROD_W'(rate_reg) * PROD_W'(dur_eff);
            rem2_reg  <= '0;
            quot2_reg <= '0;
            play_reg  <= note_playing;
        end
        else if (state_reg == ST_DIV)
        begin
            cnt_reg  <= cnt_reg + CNT_W'(1);
            prod_reg <= {prod_reg[PROD_W-2:0], 1'b0};
            // phase step quotient needs only 32 steps
            if (cnt_reg < CNT_W'(PHASE_W))
            begin
                rem1_reg  <= take1 ? RATE_W'(trial1 - {1'b0, rate_reg}) : trial1[RATE_W-1:0];
                quot1_reg <= {quot1_reg[PHASE_W-2:0], take1};
            end
            rem2_reg  <= take2 ? REM2_W'(trial2 - DUR_DIV) : trial2[REM2_W-1:0];
            quot2_reg <= {quot2_reg[QUOT2_W-2:0], take2};
        end
    end

    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input taken while note setup in progress");

    a_load_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && (func == FUNC_LOAD)) |=> (state_reg == ST_DIV) && (cnt_reg == '0))
        else $error("load did not start the dividers");

    a_div_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg < CNT_W'(DIV_STEPS)))
        else $error("divider step count overran");

    a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> (state_reg == ST_IDLE) && (phase_reg == '0))
        else $error("note commit did not return to idle with cleared phase");

endmodule
